FILE: sv/rpzt_pkg.sv
// Shared types, codes and a helper function of the RSSI proximity zone tracker.
package rpzt_pkg;

  typedef enum logic [1:0] {
    PROX_UNKNOWN = 2'd0,
    PROX_FAR     = 2'd1,
    PROX_NEAR    = 2'd2,
    PROX_INSIDE  = 2'd3
  } zone_e;

  typedef enum logic [1:0] {
    MOVE_UNKNOWN    = 2'd0,
    MOVE_STATIONARY = 2'd1,
    MOVE_APPROACH   = 2'd2,
    MOVE_DEPART     = 2'd3
  } move_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_ENTER_NEAR   = 3'd1,
    EV_ENTER_INSIDE = 3'd2,
    EV_EXIT_INSIDE  = 3'd3,
    EV_EXIT_NEAR    = 3'd4,
    EV_LOST         = 3'd5,
    EV_FOUND        = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_SUM   = 3'd1,
    SEQ_LOAD  = 3'd2,
    SEQ_DIV   = 3'd3,
    SEQ_TREND = 3'd4,
    SEQ_DONE  = 3'd5
  } seq_e;

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_LOST    = 2'd1;
  localparam logic [1:0] REQ_RESTORE = 2'd2;

  localparam logic [2:0] CFG_INSIDE_THR = 3'd0;
  localparam logic [2:0] CFG_NEAR_THR   = 3'd1;
  localparam logic [2:0] CFG_HYST       = 3'd2;
  localparam logic [2:0] CFG_DWELL      = 3'd3;
  localparam logic [2:0] CFG_LOCK_DELAY = 3'd4;
  localparam logic [2:0] CFG_MOVE_THR   = 3'd5;

  localparam logic signed [7:0] LOST_RSSI = -8'sd100;

  localparam logic signed [7:0] RST_INSIDE_THR = -8'sd55;
  localparam logic signed [7:0] RST_NEAR_THR   = -8'sd70;
  localparam logic [4:0]        RST_HYST       = 5'd5;
  localparam logic [15:0]       RST_DWELL      = 16'd1000;
  localparam logic [15:0]       RST_LOCK_DELAY = 16'd3000;
  localparam logic [6:0]        RST_MOVE_THR   = 7'd3;

  function automatic event_e transition_event(zone_e from_z, zone_e to_z);
    event_e ev;
    ev = EV_NONE;
    if (from_z == PROX_FAR && to_z == PROX_NEAR) begin
      ev = EV_ENTER_NEAR;
    end else if ((from_z == PROX_FAR || from_z == PROX_NEAR) && to_z == PROX_INSIDE) begin
      ev = EV_ENTER_INSIDE;
    end else if (from_z == PROX_INSIDE && to_z == PROX_NEAR) begin
      ev = EV_EXIT_INSIDE;
    end else if ((from_z == PROX_INSIDE || from_z == PROX_NEAR) && to_z == PROX_FAR) begin
      ev = EV_EXIT_NEAR;
    end
    return ev;
  endfunction

endpackage

FILE: sv/rssi_proximity_zone_tracker_top.sv
// Loss, restore and undefined words go from idle to done, then into the output register.
// An RSSI sample with N >= 2 ring entries goes through sum, load, divide and trend: one shared
// adder sums the ring one entry a cycle, then one restoring divider (one quotient bit a
// cycle) forms each half average; a lone first sample goes straight to the trend step.
// One word is in work at a time; the next is taken once the result sits in the output register.
// Reset loads the register defaults and the tracker state directly; no clearing pass.
module rssi_proximity_zone_tracker_top #(
  parameter int TREND_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [7:0]  rssi_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         zone_o,
  output logic [1:0]         pending_zone_o,
  output logic [1:0]         movement_o,
  output logic signed [8:0]  trend_o,
  output logic [2:0]         event_res_o,
  output logic               signal_lost_o,
  output logic signed [7:0]  current_rssi_o,
  output logic [31:0]        time_in_zone_o
);

  localparam int WI_W   = (TREND_DEPTH > 2) ? $clog2(TREND_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TREND_DEPTH + 1);
  localparam int SUM_W  = 8 + $clog2(TREND_DEPTH);
  localparam int STEP_W = $clog2(SUM_W);

  // configuration
  logic signed [7:0] inside_thr_q, near_thr_q;
  logic [4:0]        hyst_q;
  logic [15:0]       dwell_q, lock_delay_q;
  logic [6:0]        move_thr_q;

  // tracker state
  rpzt_pkg::seq_e    state_q, state_d;
  rpzt_pkg::zone_e   zone_q, zone_d, pend_q, pend_d;
  rpzt_pkg::move_e   move_q, move_d;
  rpzt_pkg::event_e  ev_q, ev_d;
  logic [31:0]       since_q, since_d, entered_q, entered_d, now_q, now_d;
  logic              lost_q, lost_d, full_q, full_d, sel_q, sel_d;
  logic              out_valid_q, out_valid_d;
  logic signed [7:0] rssi_now_q, rssi_now_d;
  logic signed [8:0] trend_q, trend_d;
  logic [WI_W-1:0]   wi_q, wi_d;

  // trend datapath
  logic signed [7:0]       hist_q [TREND_DEPTH];
  logic [WI_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]        idx_q, idx_d, count_q, count_d, divisor_q, divisor_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic signed [SUM_W-1:0] s1_q, s1_d, s2_q, s2_d;
  logic [SUM_W-1:0]        quot_q, quot_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    neg_q, neg_d;
  logic signed [8:0]       a1_q, a1_d, a2_q, a2_d;

  // output register
  logic [1:0]        zone_oq, pend_oq, move_oq;
  logic signed [8:0] trend_oq;
  logic [2:0]        ev_oq;
  logic              lost_oq;
  logic signed [7:0] rssi_oq;
  logic [31:0]       tiz_oq;
  logic              load_out;

  // threshold compares on sign-extended values
  logic signed [9:0] r10, ins10, near10, hy10;
  logic ge_in, ge_near, lt_in_m, lt_near_m, ge_in_p, ge_near_p;
  rpzt_pkg::zone_e   cls_z, det_z;
  logic [31:0]       elapsed, need;
  logic [WI_W-1:0]   wi_next;
  logic [CNT_W-1:0]  count_new;
  logic signed [SUM_W-1:0] hist_ext, dvd;
  logic [CNT_W:0]    trial;
  logic [8:0]        q9;
  logic signed [8:0] avg;
  logic signed [9:0] trend10, mt10;

  assign r10    = 10'(rssi_i);
  assign ins10  = 10'(inside_thr_q);
  assign near10 = 10'(near_thr_q);
  assign hy10   = {5'b0, hyst_q};

  assign ge_in     = r10 >= ins10;
  assign ge_near   = r10 >= near10;
  assign lt_in_m   = r10 < (ins10 - hy10);
  assign lt_near_m = r10 < (near10 - hy10);
  assign ge_in_p   = r10 >= (ins10 + hy10);
  assign ge_near_p = r10 >= (near10 + hy10);

  assign cls_z = ge_in ? rpzt_pkg::PROX_INSIDE :
                 (ge_near ? rpzt_pkg::PROX_NEAR : rpzt_pkg::PROX_FAR);

  always_comb begin
    unique case (zone_q)
      rpzt_pkg::PROX_INSIDE: begin
        det_z = lt_in_m ? (ge_near ? rpzt_pkg::PROX_NEAR : rpzt_pkg::PROX_FAR)
                        : rpzt_pkg::PROX_INSIDE;
      end
      rpzt_pkg::PROX_NEAR: begin
        det_z = ge_in_p ? rpzt_pkg::PROX_INSIDE :
                (lt_near_m ? rpzt_pkg::PROX_FAR : rpzt_pkg::PROX_NEAR);
      end
      rpzt_pkg::PROX_FAR: begin
        det_z = ge_near_p ? (ge_in_p ? rpzt_pkg::PROX_INSIDE : rpzt_pkg::PROX_NEAR)
                          : rpzt_pkg::PROX_FAR;
      end
      default: det_z = cls_z;
    endcase
  end

  assign elapsed = time_ms_i - since_q;
  assign need    = (pend_q == rpzt_pkg::PROX_FAR) ? {16'b0, lock_delay_q} : {16'b0, dwell_q};

  assign wi_next   = (wi_q == WI_W'(TREND_DEPTH - 1)) ? '0 : wi_q + 1'b1;
  assign count_new = (full_q || wi_next == '0) ? CNT_W'(TREND_DEPTH) : CNT_W'(wi_next);

  assign hist_ext = SUM_W'(hist_q[ptr_q]);
  assign dvd      = sel_q ? s2_q : s1_q;
  assign trial    = {rem_q, quot_q[SUM_W-1]} - {1'b0, divisor_q};
  assign quot_d   = (state_q == rpzt_pkg::SEQ_DIV) ? {quot_q[SUM_W-2:0], ~trial[CNT_W]}
                                                   : quot_q;
  assign q9       = quot_d[8:0];
  assign avg      = neg_q ? -$signed(q9) : $signed(q9);
  assign trend10  = 10'(a2_q) - 10'(a1_q);
  assign mt10     = {3'b0, move_thr_q};
  assign load_out = (state_q == rpzt_pkg::SEQ_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    zone_d      = zone_q;
    pend_d      = pend_q;
    move_d      = move_q;
    ev_d        = ev_q;
    since_d     = since_q;
    entered_d   = entered_q;
    now_d       = now_q;
    lost_d      = lost_q;
    full_d      = full_q;
    sel_d       = sel_q;
    rssi_now_d  = rssi_now_q;
    trend_d     = trend_q;
    wi_d        = wi_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    count_d     = count_q;
    divisor_d   = divisor_q;
    rem_d       = rem_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    step_d      = step_q;
    neg_d       = neg_q;
    a1_d        = a1_q;
    a2_d        = a2_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      rpzt_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          now_d   = time_ms_i;
          ev_d    = rpzt_pkg::EV_NONE;
          state_d = rpzt_pkg::SEQ_DONE;
          case (req_type_i)
            rpzt_pkg::REQ_SAMPLE: begin
              rssi_now_d = rssi_i;
              wi_d       = wi_next;
              if (wi_next == '0) full_d = 1'b1;
              count_d    = count_new;
              ptr_d      = (full_q || wi_next == '0) ? wi_next : '0;
              idx_d      = '0;
              s1_d       = '0;
              s2_d       = '0;
              sel_d      = 1'b0;
              a1_d       = '0;
              a2_d       = '0;
              state_d    = (count_new < CNT_W'(2)) ? rpzt_pkg::SEQ_TREND : rpzt_pkg::SEQ_SUM;
              if (lost_q) begin
                lost_d = 1'b0;
                ev_d   = rpzt_pkg::EV_FOUND;
              end
              if (det_z != zone_q) begin
                if (det_z != pend_q) begin
                  pend_d  = det_z;
                  since_d = time_ms_i;
                end else if (pend_q != rpzt_pkg::PROX_UNKNOWN && elapsed >= need) begin
                  zone_d    = det_z;
                  entered_d = time_ms_i;
                  pend_d    = rpzt_pkg::PROX_UNKNOWN;
                  if (rpzt_pkg::transition_event(zone_q, det_z) != rpzt_pkg::EV_NONE) begin
                    ev_d = rpzt_pkg::transition_event(zone_q, det_z);
                  end
                end
              end else if (pend_q != rpzt_pkg::PROX_UNKNOWN && pend_q != zone_q) begin
                pend_d = rpzt_pkg::PROX_UNKNOWN;
              end
            end
            rpzt_pkg::REQ_LOST: begin
              lost_d     = 1'b1;
              rssi_now_d = rpzt_pkg::LOST_RSSI;
              pend_d     = rpzt_pkg::PROX_FAR;
              since_d    = time_ms_i;
              ev_d       = rpzt_pkg::EV_LOST;
            end
            rpzt_pkg::REQ_RESTORE: begin
              lost_d     = 1'b0;
              rssi_now_d = rssi_i;
              if (cls_z != zone_q) begin
                zone_d    = cls_z;
                entered_d = time_ms_i;
                pend_d    = rpzt_pkg::PROX_UNKNOWN;
                ev_d      = rpzt_pkg::transition_event(rpzt_pkg::PROX_FAR, cls_z);
              end
            end
            default: ;  // undefined request: report state only
          endcase
        end
      end
      rpzt_pkg::SEQ_SUM: begin
        // accumulate older half into s1, newer half into s2
        if (idx_q < (count_q >> 1)) s1_d = s1_q + hist_ext;
        else                        s2_d = s2_q + hist_ext;
        ptr_d = (ptr_q == WI_W'(TREND_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == count_q - 1'b1) state_d = rpzt_pkg::SEQ_LOAD;
      end
      rpzt_pkg::SEQ_LOAD: begin
        neg_d     = dvd[SUM_W-1];
        rem_d     = '0;
        step_d    = '0;
        divisor_d = sel_q ? (count_q - (count_q >> 1)) : (count_q >> 1);
        state_d   = rpzt_pkg::SEQ_DIV;
      end
      rpzt_pkg::SEQ_DIV: begin
        rem_d  = trial[CNT_W] ? {rem_q[CNT_W-2:0], quot_q[SUM_W-1]} : trial[CNT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          if (!sel_q) begin
            a1_d    = avg;
            sel_d   = 1'b1;
            state_d = rpzt_pkg::SEQ_LOAD;
          end else begin
            a2_d    = avg;
            state_d = rpzt_pkg::SEQ_TREND;
          end
        end
      end
      rpzt_pkg::SEQ_TREND: begin
        trend_d = trend10[8:0];
        if (trend10 > mt10)       move_d = rpzt_pkg::MOVE_APPROACH;
        else if (trend10 < -mt10) move_d = rpzt_pkg::MOVE_DEPART;
        else                      move_d = rpzt_pkg::MOVE_STATIONARY;
        state_d = rpzt_pkg::SEQ_DONE;
      end
      rpzt_pkg::SEQ_DONE: begin
        // hold until the output register is free
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = rpzt_pkg::SEQ_IDLE;
        end
      end
      default: state_d = rpzt_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_thr_q <= rpzt_pkg::RST_INSIDE_THR;
      near_thr_q   <= rpzt_pkg::RST_NEAR_THR;
      hyst_q       <= rpzt_pkg::RST_HYST;
      dwell_q      <= rpzt_pkg::RST_DWELL;
      lock_delay_q <= rpzt_pkg::RST_LOCK_DELAY;
      move_thr_q   <= rpzt_pkg::RST_MOVE_THR;
      state_q      <= rpzt_pkg::SEQ_IDLE;
      zone_q       <= rpzt_pkg::PROX_FAR;
      pend_q       <= rpzt_pkg::PROX_UNKNOWN;
      move_q       <= rpzt_pkg::MOVE_UNKNOWN;
      ev_q         <= rpzt_pkg::EV_NONE;
      since_q      <= '0;
      entered_q    <= '0;
      lost_q       <= 1'b0;
      full_q       <= 1'b0;
      sel_q        <= 1'b0;
      rssi_now_q   <= '0;
      trend_q      <= '0;
      wi_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpzt_pkg::CFG_INSIDE_THR: inside_thr_q <= cfg_wdata_i[7:0];
          rpzt_pkg::CFG_NEAR_THR:   near_thr_q   <= cfg_wdata_i[7:0];
          rpzt_pkg::CFG_HYST:       hyst_q       <= cfg_wdata_i[4:0];
          rpzt_pkg::CFG_DWELL:      dwell_q      <= cfg_wdata_i;
          rpzt_pkg::CFG_LOCK_DELAY: lock_delay_q <= cfg_wdata_i;
          rpzt_pkg::CFG_MOVE_THR:   move_thr_q   <= cfg_wdata_i[6:0];
          default: ;  // drop writes to unused indexes
        endcase
      end
      state_q     <= state_d;
      zone_q      <= zone_d;
      pend_q      <= pend_d;
      move_q      <= move_d;
      ev_q        <= ev_d;
      since_q     <= since_d;
      entered_q   <= entered_d;
      lost_q      <= lost_d;
      full_q      <= full_d;
      sel_q       <= sel_d;
      rssi_now_q  <= rssi_now_d;
      trend_q     <= trend_d;
      wi_q        <= wi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rpzt_pkg::SEQ_IDLE && in_valid_i && req_type_i == rpzt_pkg::REQ_SAMPLE) begin
      hist_q[wi_q] <= rssi_i;
    end
    now_q     <= now_d;
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    count_q   <= count_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    step_q    <= step_d;
    neg_q     <= neg_d;
    a1_q      <= a1_d;
    a2_q      <= a2_d;
    if (state_q == rpzt_pkg::SEQ_LOAD) begin
      quot_q <= dvd[SUM_W-1] ? SUM_W'(-dvd) : SUM_W'(dvd);
    end else begin
      quot_q <= quot_d;
    end
    if (load_out) begin
      zone_oq  <= zone_q;
      pend_oq  <= pend_q;
      move_oq  <= move_q;
      trend_oq <= trend_q;
      ev_oq    <= ev_q;
      lost_oq  <= lost_q;
      rssi_oq  <= rssi_now_q;
      tiz_oq   <= now_q - entered_q;
    end
  end

  assign in_ready_o     = (state_q == rpzt_pkg::SEQ_IDLE);
  assign out_valid_o    = out_valid_q;
  assign zone_o         = zone_oq;
  assign pending_zone_o = pend_oq;
  assign movement_o     = move_oq;
  assign trend_o        = trend_oq;
  assign event_res_o    = ev_oq;
  assign signal_lost_o  = lost_oq;
  assign current_rssi_o = rssi_oq;
  assign time_in_zone_o = tiz_oq;

  // a pending zone matches the confirmed one only for far after a loss
  a_pend_match_far : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != rpzt_pkg::PROX_UNKNOWN && pend_q == zone_q) |-> pend_q == rpzt_pkg::PROX_FAR)
    else $error("pending zone equals confirmed zone other than far");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rpzt_pkg::SEQ_DIV |-> rem_q < divisor_q)
    else $error("divider remainder not below divisor");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted word");

  a_full_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("history full flag cleared");

endmodule

FILE: tb/sv/rssi_proximity_zone_tracker_top_tb.sv
// Self-checking testbench of the RSSI proximity zone tracker: directed and random link words.
module rssi_proximity_zone_tracker_top_tb;

  localparam int CLK_PERIOD = 12;
  localparam int RING_DEPTH = 8;
  localparam int TIMEOUT_CYCLES = 400000;

  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]        req;
    logic signed [7:0] rssi;
    logic [31:0]       stamp;
  } link_word_t;

  typedef struct packed {
    rpzt_pkg::zone_e   zone;
    rpzt_pkg::zone_e   pend;
    rpzt_pkg::move_e   move;
    logic signed [8:0] trend;
    rpzt_pkg::event_e  ev;
    logic              lost;
    logic signed [7:0] rssi;
    logic [31:0]       in_zone;
  } zone_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic [1:0] req_type_i = rpzt_pkg::REQ_SAMPLE;
  logic signed [7:0] rssi_i = '0;
  logic [31:0] time_ms_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [1:0] zone_o;
  logic [1:0] pending_zone_o;
  logic [1:0] movement_o;
  logic signed [8:0] trend_o;
  logic [2:0] event_res_o;
  logic signed [7:0] current_rssi_o;
  logic signal_lost_o;
  logic [31:0] time_in_zone_o;

  // Tracker configuration as the block should hold it
  logic signed [7:0] thr_inside = rpzt_pkg::RST_INSIDE_THR;
  logic signed [7:0] thr_near = rpzt_pkg::RST_NEAR_THR;
  logic [4:0] hyst = rpzt_pkg::RST_HYST;
  logic [15:0] dwell = rpzt_pkg::RST_DWELL;
  logic [15:0] lock_delay = rpzt_pkg::RST_LOCK_DELAY;
  logic [6:0] move_thr = rpzt_pkg::RST_MOVE_THR;

  // Tracker state
  logic signed [7:0] ring [RING_DEPTH] = '{default: '0};
  int ring_wr = 0;
  logic ring_full = 1'b0;
  rpzt_pkg::zone_e zone_cur = rpzt_pkg::PROX_FAR;
  rpzt_pkg::zone_e zone_pend = rpzt_pkg::PROX_UNKNOWN;
  logic [31:0] pend_since = '0;
  logic [31:0] zone_since = '0;
  logic link_lost = 1'b0;
  rpzt_pkg::move_e move_cur = rpzt_pkg::MOVE_UNKNOWN;
  logic signed [8:0] trend_cur = '0;
  logic signed [7:0] rssi_cur = '0;

  link_word_t pending_words[$];
  zone_report_t expected_reports[$];
  logic in_flight = 1'b0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int gen_level = -60;
  logic [31:0] gen_stamp = '0;

  rssi_proximity_zone_tracker_top #(
    .TREND_DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .rssi_i        (rssi_i),
    .time_ms_i     (time_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .zone_o        (zone_o),
    .pending_zone_o(pending_zone_o),
    .movement_o    (movement_o),
    .trend_o       (trend_o),
    .event_res_o   (event_res_o),
    .signal_lost_o (signal_lost_o),
    .current_rssi_o(current_rssi_o),
    .time_in_zone_o(time_in_zone_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic rpzt_pkg::zone_e plain_zone(int r);
    int ti, tn;
    ti = int'(thr_inside);
    tn = int'(thr_near);
    if (r >= ti) return rpzt_pkg::PROX_INSIDE;
    if (r >= tn) return rpzt_pkg::PROX_NEAR;
    return rpzt_pkg::PROX_FAR;
  endfunction

  // Leaving the held zone needs the margin; an unknown zone is classified plainly
  function automatic rpzt_pkg::zone_e zone_seen(int r, rpzt_pkg::zone_e held);
    int ti, tn, h;
    ti = int'(thr_inside);
    tn = int'(thr_near);
    h = int'(hyst);
    case (held)
      rpzt_pkg::PROX_INSIDE: begin
        if (r < ti - h) return (r >= tn) ? rpzt_pkg::PROX_NEAR : rpzt_pkg::PROX_FAR;
        return rpzt_pkg::PROX_INSIDE;
      end
      rpzt_pkg::PROX_NEAR: begin
        if (r >= ti + h) return rpzt_pkg::PROX_INSIDE;
        if (r < tn - h) return rpzt_pkg::PROX_FAR;
        return rpzt_pkg::PROX_NEAR;
      end
      rpzt_pkg::PROX_FAR: begin
        if (r >= tn + h) return (r >= ti + h) ? rpzt_pkg::PROX_INSIDE : rpzt_pkg::PROX_NEAR;
        return rpzt_pkg::PROX_FAR;
      end
      default: return plain_zone(r);
    endcase
  endfunction

  // Newer-half average minus older-half average, each truncated toward zero
  function automatic int ring_trend();
    int count, half, lo_sum, hi_sum, slot;
    count = ring_full ? RING_DEPTH : ring_wr;
    if (count < 2) return 0;
    half = count / 2;
    lo_sum = 0;
    hi_sum = 0;
    for (int i = 0; i < count; i++) begin
      slot = (ring_wr + RING_DEPTH - count + i) % RING_DEPTH;
      if (i < half) lo_sum += int'(ring[slot]);
      else hi_sum += int'(ring[slot]);
    end
    return hi_sum / (count - half) - lo_sum / half;
  endfunction

  function automatic rpzt_pkg::event_e zone_change_event(rpzt_pkg::zone_e from_z,
                                                         rpzt_pkg::zone_e to_z);
    case (to_z)
      rpzt_pkg::PROX_NEAR: begin
        if (from_z == rpzt_pkg::PROX_FAR) return rpzt_pkg::EV_ENTER_NEAR;
        if (from_z == rpzt_pkg::PROX_INSIDE) return rpzt_pkg::EV_EXIT_INSIDE;
        return rpzt_pkg::EV_NONE;
      end
      rpzt_pkg::PROX_INSIDE: begin
        return (from_z == rpzt_pkg::PROX_FAR || from_z == rpzt_pkg::PROX_NEAR) ?
               rpzt_pkg::EV_ENTER_INSIDE : rpzt_pkg::EV_NONE;
      end
      rpzt_pkg::PROX_FAR: begin
        return (from_z == rpzt_pkg::PROX_NEAR || from_z == rpzt_pkg::PROX_INSIDE) ?
               rpzt_pkg::EV_EXIT_NEAR : rpzt_pkg::EV_NONE;
      end
      default: return rpzt_pkg::EV_NONE;
    endcase
  endfunction

  function automatic zone_report_t track_word(logic [1:0] req, logic signed [7:0] rssi,
                                              logic [31:0] now);
    zone_report_t rep;
    rpzt_pkg::event_e ev;
    rpzt_pkg::event_e moved;
    rpzt_pkg::zone_e seen;
    rpzt_pkg::zone_e prev;
    logic [31:0] need;
    int r, tr, mt;
    ev = rpzt_pkg::EV_NONE;
    r = int'(rssi);
    case (req)
      rpzt_pkg::REQ_SAMPLE: begin
        rssi_cur = rssi;
        ring[ring_wr] = rssi;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_wr == 0) ring_full = 1'b1;
        tr = ring_trend();
        trend_cur = tr[8:0];
        mt = int'(move_thr);
        if (tr > mt) move_cur = rpzt_pkg::MOVE_APPROACH;
        else if (tr < -mt) move_cur = rpzt_pkg::MOVE_DEPART;
        else move_cur = rpzt_pkg::MOVE_STATIONARY;
        if (link_lost) begin
          link_lost = 1'b0;
          ev = rpzt_pkg::EV_FOUND;
        end
        seen = zone_seen(r, zone_cur);
        if (seen != zone_cur) begin
          if (seen != zone_pend) begin
            zone_pend = seen;
            pend_since = now;
          end else begin
            need = (zone_pend == rpzt_pkg::PROX_FAR) ? 32'(lock_delay) : 32'(dwell);
            if (zone_pend != rpzt_pkg::PROX_UNKNOWN && now - pend_since >= need) begin
              prev = zone_cur;
              zone_cur = seen;
              zone_since = now;
              zone_pend = rpzt_pkg::PROX_UNKNOWN;
              moved = zone_change_event(prev, seen);
              // a confirmed transition overrides found
              if (moved != rpzt_pkg::EV_NONE) ev = moved;
            end
          end
        end else if (zone_pend != rpzt_pkg::PROX_UNKNOWN && zone_pend != zone_cur) begin
          zone_pend = rpzt_pkg::PROX_UNKNOWN;
        end
      end
      rpzt_pkg::REQ_LOST: begin
        link_lost = 1'b1;
        rssi_cur = rpzt_pkg::LOST_RSSI;
        zone_pend = rpzt_pkg::PROX_FAR;
        pend_since = now;
        ev = rpzt_pkg::EV_LOST;
      end
      rpzt_pkg::REQ_RESTORE: begin
        link_lost = 1'b0;
        rssi_cur = rssi;
        seen = plain_zone(r);
        if (seen != zone_cur) begin
          zone_cur = seen;
          zone_since = now;
          zone_pend = rpzt_pkg::PROX_UNKNOWN;
          ev = zone_change_event(rpzt_pkg::PROX_FAR, seen);
        end
      end
      default: ;
    endcase
    rep.zone = zone_cur;
    rep.pend = zone_pend;
    rep.move = move_cur;
    rep.trend = trend_cur;
    rep.ev = ev;
    rep.lost = link_lost;
    rep.rssi = rssi_cur;
    rep.in_zone = now - zone_since;
    return rep;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Take a word and queue its expected report
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_reports.push_back(track_word(req_type_i, rssi_i, time_ms_i));
      in_flight = 1'b0;
    end
  end

  always @(negedge clk_i) begin : word_driver
    link_word_t nxt;
    if (!in_flight) begin
      if (pending_words.size() != 0 &&
          ((words_sent >= 300 && words_sent < 450) || $urandom_range(99) >= 31)) begin
        nxt = pending_words.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.req;
        rssi_i <= nxt.rssi;
        time_ms_i <= nxt.stamp;
        in_flight = 1'b1;
        words_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 600) begin
      // hold off long enough for the block to back up onto its input
      hold_done = 1'b1;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (results_seen >= 250 && results_seen < 400) || $urandom_range(99) >= 31;
    end
  end

  always @(posedge clk_i) begin : report_monitor
    zone_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        $error("unexpected result word");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("zone", longint'(want.zone), longint'(zone_o));
        check_field("pending_zone", longint'(want.pend), longint'(pending_zone_o));
        check_field("movement", longint'(want.move), longint'(movement_o));
        check_field("trend", longint'(want.trend), longint'(trend_o));
        check_field("event_res", longint'(want.ev), longint'(event_res_o));
        check_field("signal_lost", longint'(want.lost), longint'(signal_lost_o));
        check_field("current_rssi", longint'(want.rssi), longint'(current_rssi_o));
        check_field("time_in_zone", longint'(want.in_zone), longint'(time_in_zone_o));
      end
    end
  end

  task automatic add_word(logic [1:0] req, int rssi, logic [31:0] stamp);
    link_word_t w;
    w.req = req;
    w.rssi = rssi[7:0];
    w.stamp = stamp;
    pending_words.push_back(w);
  endtask

  // Mostly runs of samples around a level close to a threshold, with losses, restores, undefined words and noise
  task automatic add_random_words(int count);
    int kind, jump, r;
    logic [1:0] req;
    for (int n = 0; n < count; n++) begin
      jump = $urandom_range(99);
      if (jump < 60) gen_stamp += $urandom_range(400);
      else if (jump < 90) gen_stamp += $urandom_range(3000, 400);
      else if (jump < 97) gen_stamp += $urandom_range(70000, 3000);
      else gen_stamp = $urandom;
      if ($urandom_range(5) == 0) begin
        gen_level = $urandom_range(1) ? int'(thr_inside) : int'(thr_near);
        gen_level += int'($urandom_range(2 * int'(hyst) + 12)) - (int'(hyst) + 6);
      end
      r = gen_level + int'($urandom_range(4)) - 2;
      if ($urandom_range(9) == 0) r = int'($urandom_range(255)) - 128;
      if (r > 127) r = 127;
      if (r < -128) r = -128;
      kind = $urandom_range(99);
      if (kind < 4) req = rpzt_pkg::REQ_LOST;
      else if (kind < 8) req = rpzt_pkg::REQ_RESTORE;
      else if (kind < 11) req = REQ_UNDEF;
      else req = rpzt_pkg::REQ_SAMPLE;
      add_word(req, r, gen_stamp);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      rpzt_pkg::CFG_INSIDE_THR: thr_inside = data[7:0];
      rpzt_pkg::CFG_NEAR_THR:   thr_near = data[7:0];
      rpzt_pkg::CFG_HYST:       hyst = data[4:0];
      rpzt_pkg::CFG_DWELL:      dwell = data;
      rpzt_pkg::CFG_LOCK_DELAY: lock_delay = data;
      rpzt_pkg::CFG_MOVE_THR:   move_thr = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_phase(int p);
    int ins, nr, swap;
    logic [4:0] h;
    logic [15:0] dw, lk;
    logic [6:0] mt;
    if (p == 0) begin
      ins = -128;
      nr = -128;
      h = 5'd0;
      dw = 16'd0;
      lk = 16'd0;
      mt = 7'd0;
    end else if (p == 1) begin
      ins = 0;
      nr = 0;
      h = 5'd31;
      dw = 16'hFFFF;
      lk = 16'hFFFF;
      mt = 7'd127;
    end else begin
      ins = -int'($urandom_range(70, 20));
      nr = ins - int'($urandom_range(30));
      if (nr < -128) nr = -128;
      // thresholds in the wrong order once
      if (p == 4) begin
        swap = ins;
        ins = nr;
        nr = swap;
      end
      h = 5'($urandom_range(31));
      dw = 16'($urandom_range(3000));
      lk = 16'($urandom_range(6000));
      mt = 7'($urandom_range(12));
    end
    write_reg(rpzt_pkg::CFG_INSIDE_THR, {{8{ins[7]}}, ins[7:0]});
    write_reg(rpzt_pkg::CFG_NEAR_THR, {{8{nr[7]}}, nr[7:0]});
    write_reg(rpzt_pkg::CFG_HYST, {11'd0, h});
    write_reg(rpzt_pkg::CFG_DWELL, dw);
    write_reg(rpzt_pkg::CFG_LOCK_DELAY, lk);
    write_reg(rpzt_pkg::CFG_MOVE_THR, {9'd0, mt});
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_flight || expected_reports.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset thresholds: inside -55, near -70, margin 5, dwell 1000, lock 3000
    add_word(rpzt_pkg::REQ_SAMPLE, -128, 32'd0);
    add_word(rpzt_pkg::REQ_SAMPLE, 127, 32'd10);
    add_word(rpzt_pkg::REQ_SAMPLE, 127, 32'd500);
    add_word(rpzt_pkg::REQ_SAMPLE, 127, 32'd1010);
    add_word(rpzt_pkg::REQ_SAMPLE, -60, 32'd1100);
    add_word(rpzt_pkg::REQ_SAMPLE, -61, 32'd1200);
    add_word(rpzt_pkg::REQ_SAMPLE, -61, 32'd2200);
    add_word(rpzt_pkg::REQ_LOST, 85, 32'd2300);
    add_word(rpzt_pkg::REQ_SAMPLE, -65, 32'd2400);
    add_word(REQ_UNDEF, -7, 32'd2500);
    add_word(rpzt_pkg::REQ_RESTORE, -40, 32'd2600);
    add_word(rpzt_pkg::REQ_RESTORE, -90, 32'd2700);
    add_word(rpzt_pkg::REQ_RESTORE, -90, 32'd2800);
    // loss while already far: pending far stays put
    add_word(rpzt_pkg::REQ_LOST, -1, 32'd2900);
    add_word(rpzt_pkg::REQ_SAMPLE, -128, 32'd3000);
    add_word(rpzt_pkg::REQ_SAMPLE, -128, 32'd6000);
    // dwell measured across the timestamp wrap
    add_word(rpzt_pkg::REQ_SAMPLE, -50, 32'hFFFF_FF00);
    add_word(rpzt_pkg::REQ_SAMPLE, -50, 32'h0000_0300);
    add_word(rpzt_pkg::REQ_SAMPLE, 0, 32'h0000_0400);
    add_word(rpzt_pkg::REQ_SAMPLE, -1, 32'h0000_0450);
    add_word(rpzt_pkg::REQ_SAMPLE, -75, 32'h0000_0500);
    add_word(rpzt_pkg::REQ_SAMPLE, -75, 32'h0000_10C0);
    add_word(REQ_UNDEF, 127, 32'hFFFF_FFFF);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      set_phase(p);
      if (p == 5) gen_stamp = 32'hFFFF_8000;
      add_random_words(150);
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: rssi_proximity_zone_tracker_top.f
sv/rpzt_pkg.sv
sv/rssi_proximity_zone_tracker_top.sv
tb/sv/rssi_proximity_zone_tracker_top_tb.sv
